/* hw/rtl/hlf_pkg.sv */
// Shared widths, operation and status codes, and word types for the handle table.
package hlf_pkg;

   localparam int unsigned DEF_CAPACITY   = 64;
   localparam int unsigned DEF_ENTRY_BITS = 32;

   localparam int unsigned KIND_W   = 2;
   localparam int unsigned HANDLE_W = 8;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned SLOT_W   = 6;
   localparam int unsigned OLD_W    = 32;
   localparam int unsigned STATUS_W = 2;

   localparam int unsigned CMDQ_DEPTH = 2;
   localparam int unsigned RSPQ_DEPTH = 2;

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_GET    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SET    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_DROP   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [HANDLE_W-1:0] handle;
      logic [VALUE_W-1:0]  value;
      logic                range_err;
   } cmd_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      logic [OLD_W-1:0]    old_value;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

/* hw/rtl/handle_table_lowest_free.sv */
// Top level of the handle table with lowest-free insert.
// A request word passes through the command queue, the execute registers and the response queue.
// The back end takes no new command until the write-back of the current one is done.
// Insert picks the lowest free slot from an occupancy bit vector in the same cycle as the read.
// Reset clears the occupancy bits and both queues at once; the entry memory itself is not swept.
module handle_table_lowest_free #(
   parameter int unsigned CAPACITY   = hlf_pkg::DEF_CAPACITY,
   parameter int unsigned ENTRY_BITS = hlf_pkg::DEF_ENTRY_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [hlf_pkg::KIND_W-1:0]    req_kind,
   input  logic [hlf_pkg::HANDLE_W-1:0]  req_handle,
   input  logic [hlf_pkg::VALUE_W-1:0]   req_value,
   output logic                          empty,
   input  logic                          pop,
   output logic [hlf_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [hlf_pkg::OLD_W-1:0]     rsp_old_value,
   output logic [hlf_pkg::STATUS_W-1:0]  rsp_status
);
   import hlf_pkg::*;

   cmd_type   cmd;
   logic      cmd_valid;
   logic      cmd_pop;
   rsp_type   rsp;
   logic      rsp_push;
   logic      rsp_full;

   hlf_front #(
      .CAPACITY (CAPACITY)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .kind      (req_kind),
      .handle    (req_handle),
      .value     (req_value),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   hlf_exec #(
      .CAPACITY   (CAPACITY),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_exec (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp)
   );

   hlf_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .rsp_in    (rsp),
      .full      (rsp_full),
      .empty     (empty),
      .pop       (pop),
      .slot      (rsp_slot),
      .old_value (rsp_old_value),
      .status    (rsp_status)
   );

endmodule

/* hw/rtl/hlf_front.sv */
// Front end: accepts request words, checks the handle range and queues commands.
module hlf_front #(
   parameter int unsigned CAPACITY = hlf_pkg::DEF_CAPACITY
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [hlf_pkg::KIND_W-1:0]    kind,
   input  logic [hlf_pkg::HANDLE_W-1:0]  handle,
   input  logic [hlf_pkg::VALUE_W-1:0]   value,
   output logic                          cmd_valid,
   output hlf_pkg::cmd_type              cmd,
   input  logic                          cmd_pop
);
   import hlf_pkg::*;

   localparam int unsigned PTR_W = $clog2(CMDQ_DEPTH);
   localparam int unsigned CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type            q_ff [CMDQ_DEPTH];
   cmd_type            new_cmd;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == CNT_W'(CMDQ_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      new_cmd.kind      = kind;
      new_cmd.handle    = handle;
      new_cmd.value     = value;
      new_cmd.range_err = (kind != KIND_INSERT) &&
                          ({1'b0, handle} >= (HANDLE_W + 1)'(CAPACITY));
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

/* hw/rtl/hlf_exec.sv */
// Back end: entry memory, occupancy bits, lowest-free search and read then write-back.
module hlf_exec #(
   parameter int unsigned CAPACITY   = hlf_pkg::DEF_CAPACITY,
   parameter int unsigned ENTRY_BITS = hlf_pkg::DEF_ENTRY_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  hlf_pkg::cmd_type  cmd,
   output logic              cmd_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output hlf_pkg::rsp_type  rsp
);
   import hlf_pkg::*;

   localparam int unsigned IDX_W = $clog2(CAPACITY);

   localparam logic S_IDLE  = 1'b0;
   localparam logic S_WRITE = 1'b1;

   logic [ENTRY_BITS-1:0]            mem [CAPACITY];
   logic [ENTRY_BITS-1:0]            rd_data_ff;
   logic [CAPACITY-1:0]              valid_ff, valid_in;
   logic                             state_ff, state_in;
   cmd_type                          cmd_ff;
   logic [IDX_W-1:0]                 idx_ff;
   logic [IDX_W-1:0]                 idx_sel;
   logic                             table_full_ff;
   logic [IDX_W-1:0]                 free_idx;
   logic                             any_free;
   logic                             start;
   logic                             is_insert;
   logic                             write_en;
   logic [ENTRY_BITS+VALUE_W-1:0]    value_pad;
   logic [ENTRY_BITS-1:0]            wdata;
   logic [ENTRY_BITS+OLD_W-1:0]      old_pad;
   logic [IDX_W+SLOT_W-1:0]          slot_pad;
   logic [HANDLE_W-1:0]              handle_idx_pad;

   always_comb begin
      free_idx = '0;
      any_free = 1'b0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
            any_free = 1'b1;
         end
      end
   end

   assign start   = (state_ff == S_IDLE) && cmd_valid && !rsp_full;
   assign cmd_pop = start;

   assign handle_idx_pad = cmd.handle;
   assign idx_sel = (cmd.kind == KIND_INSERT) ? free_idx : handle_idx_pad[IDX_W-1:0];

   assign is_insert = (cmd_ff.kind == KIND_INSERT);
   assign value_pad = {{ENTRY_BITS{1'b0}}, cmd_ff.value};
   assign wdata     = (cmd_ff.kind == KIND_DROP) ? '0 : value_pad[ENTRY_BITS-1:0];
   assign write_en  = (state_ff == S_WRITE) &&
                      ((is_insert && !table_full_ff) ||
                       (!is_insert && !cmd_ff.range_err &&
                        (cmd_ff.kind == KIND_SET || cmd_ff.kind == KIND_DROP)));

   assign old_pad  = {{OLD_W{1'b0}}, rd_data_ff};
   assign slot_pad = {{SLOT_W{1'b0}}, idx_ff};

   always_comb begin
      rsp.slot      = cmd_ff.handle[SLOT_W-1:0];
      rsp.old_value = '0;
      rsp.status    = STATUS_OK;
      if (is_insert) begin
         if (table_full_ff) begin
            rsp.slot   = '0;
            rsp.status = STATUS_FULL;
         end else begin
            rsp.slot = slot_pad[SLOT_W-1:0];
         end
      end else if (cmd_ff.range_err) begin
         rsp.status = STATUS_RANGE;
      end else if (valid_ff[idx_ff]) begin
         rsp.old_value = old_pad[OLD_W-1:0];
      end
   end

   assign rsp_push = (state_ff == S_WRITE);

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            state_in = S_IDLE;
            if (write_en) begin
               valid_in[idx_ff] = (wdata != '0);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cmd_ff        <= cmd;
         idx_ff        <= idx_sel;
         table_full_ff <= !any_free;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[idx_sel];
      if (write_en) begin
         mem[idx_ff] <= wdata;
      end
   end

endmodule

/* hw/rtl/hlf_rsp_queue.sv */
// Result queue that holds finished response words until they are popped.
module hlf_rsp_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  hlf_pkg::rsp_type              rsp_in,
   output logic                          full,
   output logic                          empty,
   input  logic                          pop,
   output logic [hlf_pkg::SLOT_W-1:0]    slot,
   output logic [hlf_pkg::OLD_W-1:0]     old_value,
   output logic [hlf_pkg::STATUS_W-1:0]  status
);
   import hlf_pkg::*;

   localparam int unsigned PTR_W = $clog2(RSPQ_DEPTH);
   localparam int unsigned CNT_W = $clog2(RSPQ_DEPTH + 1);

   rsp_type            q_ff [RSPQ_DEPTH];
   rsp_type            head;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == CNT_W'(RSPQ_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head      = q_ff[rd_ptr_ff];
   assign slot      = head.slot;
   assign old_value = head.old_value;
   assign status    = head.status;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(RSPQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(RSPQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= rsp_in;
      end
   end

endmodule

/* tb/handle_table_checker.sv */
// Checker for the handle table: tracks the table contents and compares every response word.
`timescale 1ns / 1ps

module handle_table_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic                          full,
   input  logic [hlf_pkg::KIND_W-1:0]    req_kind,
   input  logic [hlf_pkg::HANDLE_W-1:0]  req_handle,
   input  logic [hlf_pkg::VALUE_W-1:0]   req_value,
   input  logic                          empty,
   input  logic                          pop,
   input  logic [hlf_pkg::SLOT_W-1:0]    rsp_slot,
   input  logic [hlf_pkg::OLD_W-1:0]     rsp_old_value,
   input  logic [hlf_pkg::STATUS_W-1:0]  rsp_status,
   output int                            mismatch_count,
   output int                            pending_words
);
   import hlf_pkg::*;

   localparam int unsigned CAPACITY = DEF_CAPACITY;

   logic [DEF_ENTRY_BITS-1:0] table_image [CAPACITY];
   rsp_type                   response_q [$];

   function automatic rsp_type table_access(logic [KIND_W-1:0] kind,
                                            logic [HANDLE_W-1:0] hnd,
                                            logic [VALUE_W-1:0] val);
      rsp_type rsp;
      int      free_slot;
      rsp = '0;
      free_slot = -1;
      if (kind == KIND_INSERT) begin
         for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (table_image[i] == '0) free_slot = i;
         end
         if (free_slot < 0) begin
            rsp.status = STATUS_FULL;
         end else begin
            table_image[free_slot] = val[DEF_ENTRY_BITS-1:0];
            rsp.slot = SLOT_W'(free_slot);
            rsp.status = STATUS_OK;
         end
      end else if (hnd >= CAPACITY) begin
         rsp.slot = hnd[SLOT_W-1:0];
         rsp.status = STATUS_RANGE;
      end else begin
         rsp.slot = hnd[SLOT_W-1:0];
         rsp.old_value = OLD_W'(table_image[hnd]);
         rsp.status = STATUS_OK;
         if (kind == KIND_SET) begin
            table_image[hnd] = val[DEF_ENTRY_BITS-1:0];
         end else if (kind == KIND_DROP) begin
            table_image[hnd] = '0;
         end
      end
      return rsp;
   endfunction

   task automatic compare_field(string field, logic [OLD_W-1:0] want, logic [OLD_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (table_image[i]) table_image[i] = '0;
         response_q.delete();
      end else begin
         // A response word can never belong to a request taken at the same edge,
         // so the response side is handled first.
         if (pop && !empty) begin
            if (response_q.size() == 0) begin
               $error("response word with no request outstanding: slot 0x%0h", rsp_slot);
               mismatch_count++;
            end else begin
               want = response_q.pop_front();
               compare_field("slot", OLD_W'(want.slot), OLD_W'(rsp_slot));
               compare_field("old_value", want.old_value, rsp_old_value);
               compare_field("status", OLD_W'(want.status), OLD_W'(rsp_status));
            end
         end
         if (push && !full) begin
            response_q.push_back(table_access(req_kind, req_handle, req_value));
         end
      end
      pending_words <= response_q.size();
   end

endmodule

/* tb/testbench.sv */
// Top of the handle table testbench: clock, reset, request and response stimulus, and verdict.
`timescale 1ns / 1ps

module testbench;
   import hlf_pkg::*;

   localparam int unsigned CAPACITY    = DEF_CAPACITY;
   localparam int          NUM_PHASES  = 7;
   localparam int          PHASE_WORDS = 250;

   logic                clock = 1'b0;
   logic                reset;
   logic                push;
   logic                full;
   logic [KIND_W-1:0]   req_kind;
   logic [HANDLE_W-1:0] req_handle;
   logic [VALUE_W-1:0]  req_value;
   logic                empty;
   logic                pop;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [OLD_W-1:0]    rsp_old_value;
   logic [STATUS_W-1:0] rsp_status;
   int                  mismatch_count;
   int                  pending_words;
   bit                  calm = 1'b0;

   int unsigned insert_pct [NUM_PHASES] = '{70, 40, 15, 80, 45, 25, 60};
   int unsigned drop_pct   [NUM_PHASES] = '{10, 30, 60, 5, 35, 25, 20};

   handle_table_lowest_free u_top (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_kind      (req_kind),
      .req_handle    (req_handle),
      .req_value     (req_value),
      .empty         (empty),
      .pop           (pop),
      .rsp_slot      (rsp_slot),
      .rsp_old_value (rsp_old_value),
      .rsp_status    (rsp_status)
   );

   handle_table_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_kind       (req_kind),
      .req_handle     (req_handle),
      .req_value      (req_value),
      .empty          (empty),
      .pop            (pop),
      .rsp_slot       (rsp_slot),
      .rsp_old_value  (rsp_old_value),
      .rsp_status     (rsp_status),
      .mismatch_count (mismatch_count),
      .pending_words  (pending_words)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int gap;
      pop <= 1'b0;
      forever begin
         if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 15);
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic send_word(logic [KIND_W-1:0] kind, logic [HANDLE_W-1:0] hnd,
                            logic [VALUE_W-1:0] val);
      int gap;
      if (!calm && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 15);
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_kind <= kind;
      req_handle <= hnd;
      req_value <= val;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      push <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
   endtask

   initial begin
      int                  roll;
      logic [KIND_W-1:0]   kind;
      logic [HANDLE_W-1:0] hnd;
      logic [VALUE_W-1:0]  val;
      reset <= 1'b1;
      push <= 1'b0;
      req_kind <= KIND_INSERT;
      req_handle <= '0;
      req_value <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Inserting zero hands out the lowest slot but leaves it free.
      send_word(KIND_INSERT, 8'd0, 32'h0000_0000);
      send_word(KIND_INSERT, 8'hFF, 32'hFFFF_FFFF);
      send_word(KIND_INSERT, 8'd0, 32'h0000_0001);
      send_word(KIND_GET, 8'd0, 32'h0);
      send_word(KIND_GET, 8'd1, 32'h0);
      send_word(KIND_GET, 8'd2, 32'h0);
      send_word(KIND_GET, 8'd63, 32'h0);
      send_word(KIND_GET, 8'd64, 32'h0);
      send_word(KIND_GET, 8'd255, 32'h0);
      send_word(KIND_SET, 8'd63, 32'hA5A5_5A5A);
      send_word(KIND_GET, 8'd63, 32'h0);
      send_word(KIND_SET, 8'd63, 32'h0000_0000);
      send_word(KIND_GET, 8'd63, 32'h0);
      send_word(KIND_SET, 8'd128, 32'h1234_5678);
      send_word(KIND_DROP, 8'd1, 32'h0);
      send_word(KIND_DROP, 8'd1, 32'h0);
      send_word(KIND_DROP, 8'd200, 32'h0);
      send_word(KIND_INSERT, 8'd0, 32'h8000_0000);
      send_word(KIND_SET, 8'd5, 32'hFFFF_FFFF);
      send_word(KIND_INSERT, 8'd0, 32'h0F0F_F0F0);
      send_word(KIND_DROP, 8'd0, 32'h0);
      send_word(KIND_INSERT, 8'd0, 32'h0000_0002);
      wait_for_drain();

      // Each phase leans toward filling, churning or emptying the table.
      for (int p = 0; p < NUM_PHASES; p++) begin
         calm = (p == NUM_PHASES - 1);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < insert_pct[p]) begin
               kind = KIND_INSERT;
            end else if (roll < insert_pct[p] + drop_pct[p]) begin
               kind = KIND_DROP;
            end else begin
               kind = ($urandom_range(0, 1) == 0) ? KIND_GET : KIND_SET;
            end
            if ($urandom_range(0, 99) < 85) begin
               hnd = HANDLE_W'($urandom_range(0, CAPACITY - 1));
            end else begin
               hnd = HANDLE_W'($urandom_range(CAPACITY, 255));
            end
            roll = $urandom_range(0, 19);
            if (roll == 0) begin
               val = '0;
            end else if (roll == 1) begin
               val = '1;
            end else begin
               val = $urandom;
            end
            send_word(kind, hnd, val);
         end
         wait_for_drain();
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
